FILE: src/bpq_pkg.sv
// Shared types and command codes for the bucketed priority queue.
// No dependencies; every other file in src imports this package.
package bpq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } bpq_cmd_e;

  // One request beat.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  priority_req;
    logic [15:0] tag;
  } bpq_req_t;

  // One response beat.
  typedef struct packed {
    logic        ok;
    logic [15:0] out_tag;
    logic [3:0]  out_priority;
    logic [6:0]  count;
    logic        empty_res;
  } bpq_rsp_t;

  // State updates decided by the command decoder for one beat.
  typedef struct packed {
    logic enq;
    logic deq;
  } bpq_op_t;

endpackage

FILE: src/bpq_node_mem.sv
// Entry storage: per-slot link to the next slot of the same level and the tag.
// One write port, one registered read port with write-through; uses bpq_pkg.
module bpq_node_mem
  import bpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_slot_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_link_i,
  input  logic [TAG_BITS-1:0]         wr_tag_i,
  input  logic [$clog2(CAPACITY)-1:0] rd_slot_i,
  output logic [$clog2(CAPACITY)-1:0] rd_link_o,
  output logic [TAG_BITS-1:0]         rd_tag_o
);

  localparam int SlotW = $clog2(CAPACITY);

  logic [SlotW-1:0]    link_mem [CAPACITY];
  logic [TAG_BITS-1:0] tag_mem  [CAPACITY];
  logic [SlotW-1:0]    rd_link_q;
  logic [TAG_BITS-1:0] rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      link_mem[wr_slot_i] <= wr_link_i;
      tag_mem[wr_slot_i]  <= wr_tag_i;
    end
    // A write to the slot being fetched wins over the old contents.
    if (we_i && (wr_slot_i == rd_slot_i)) begin
      rd_link_q <= wr_link_i;
      rd_tag_q  <= wr_tag_i;
    end else begin
      rd_link_q <= link_mem[rd_slot_i];
      rd_tag_q  <= tag_mem[rd_slot_i];
    end
  end

  assign rd_link_o = rd_link_q;
  assign rd_tag_o  = rd_tag_q;

endmodule

FILE: src/bpq_free_stack.sv
// Free-slot stack with entry count and a prefetched top of stack.
// Entries above the high-water mark read as their own index; uses bpq_pkg.
module bpq_free_stack
  import bpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpq_op_t                       op_i,
  input  logic [$clog2(CAPACITY)-1:0]   push_slot_i,
  output logic [$clog2(CAPACITY)-1:0]   top_slot_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_q_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_d_o
);

  localparam int SlotW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);

  logic [SlotW-1:0] stack_mem [CAPACITY];
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  peak_q, peak_d;
  logic [SlotW-1:0] top_q;
  logic [CntW-1:0]  wr_pos, rd_pos;
  logic [CntW:0]    count_inc;
  logic             fresh;

  always_comb begin
    count_d = count_q;
    if (op_i.enq) begin
      count_d = count_q + CntW'(1);
    end else if (op_i.deq) begin
      count_d = count_q - CntW'(1);
    end
    peak_d = (count_d > peak_q) ? count_d : peak_q;
  end

  // A dequeue pushes at CAPACITY-count, which is exactly the next read position.
  assign wr_pos    = CntW'(CAPACITY) - count_q;
  assign rd_pos    = CntW'(CAPACITY - 1) - count_d;
  assign count_inc = {1'b0, count_d} + (CntW + 1)'(1);
  // Positions the count has never come back down through were never written.
  assign fresh     = count_inc > {1'b0, peak_d};

  always_ff @(posedge clk_i) begin
    if (op_i.deq) begin
      stack_mem[wr_pos[SlotW-1:0]] <= push_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
      top_q   <= SlotW'(CAPACITY - 1);
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      if (op_i.deq) begin
        top_q <= push_slot_i;
      end else if (fresh) begin
        top_q <= rd_pos[SlotW-1:0];
      end else begin
        top_q <= stack_mem[rd_pos[SlotW-1:0]];
      end
    end
  end

  assign top_slot_o = top_q;
  assign count_q_o  = count_q;
  assign count_d_o  = count_d;

endmodule

FILE: src/bpq_level_tbl.sv
// Per-level head slots and non-empty flags, lowest non-empty level encoder,
// and the registered front slot of the queue; uses bpq_pkg.
module bpq_level_tbl
  import bpq_pkg::*;
#(
  parameter int LEVELS   = 16,
  parameter int CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpq_op_t                     op_i,
  input  logic [$clog2(LEVELS)-1:0]   enq_level_i,
  input  logic [$clog2(CAPACITY)-1:0] enq_slot_i,
  input  logic [$clog2(CAPACITY)-1:0] deq_link_i,
  output logic [$clog2(CAPACITY)-1:0] enq_link_o,
  output logic                        any_o,
  output logic [$clog2(LEVELS)-1:0]   first_o,
  output logic [$clog2(CAPACITY)-1:0] front_slot_o,
  output logic [$clog2(CAPACITY)-1:0] front_slot_d_o
);

  localparam int LvlW  = $clog2(LEVELS);
  localparam int SlotW = $clog2(CAPACITY);

  logic [SlotW-1:0]  head_q [LEVELS];
  logic [SlotW-1:0]  head_d [LEVELS];
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [LvlW-1:0]   first_q, first_d;
  logic [SlotW-1:0]  front_slot_q, front_slot_d;

  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    if (op_i.enq) begin
      head_d[enq_level_i]     = enq_slot_i;
      nonempty_d[enq_level_i] = 1'b1;
    end else if (op_i.deq) begin
      // A slot linked to itself is the last one of its level.
      if (deq_link_i == front_slot_q) begin
        nonempty_d[first_q] = 1'b0;
      end else begin
        head_d[first_q] = deq_link_i;
      end
    end
  end

  always_comb begin
    first_d = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_d[i]) begin
        first_d = LvlW'(i);
      end
    end
    front_slot_d = head_d[first_d];
  end

  assign enq_link_o = nonempty_q[enq_level_i] ? head_q[enq_level_i] : enq_slot_i;

  always_ff @(posedge clk_i) begin
    head_q       <= head_d;
    front_slot_q <= front_slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      first_q    <= '0;
    end else begin
      nonempty_q <= nonempty_d;
      first_q    <= first_d;
    end
  end

  assign any_o          = |nonempty_q;
  assign first_o        = first_q;
  assign front_slot_o   = front_slot_q;
  assign front_slot_d_o = front_slot_d;

endmodule

FILE: src/bucketed_priority_queue_top.sv
// Bucketed priority queue: command decode, state update and response buffer.
// Instantiates bpq_level_tbl, bpq_node_mem and bpq_free_stack; uses bpq_pkg.
//
// Usage:
//   Requests arrive on in_valid_i / in_data_i and are taken at a clock edge
//   where in_valid_i is high and in_stall_o is low. Each request beat yields
//   exactly one response beat on out_valid_o / out_data_o, taken when
//   out_stall_i is low. Enqueue stores a tag at its level (newest first within
//   a level), dequeue removes and peek returns the front entry of the lowest
//   non-empty level. Every response carries the count and empty flag.
//   Each response is registered before it is shown on out_data_o.
//   Throughput is one command per cycle while in_stall_o is low; the front
//   entry of the queue and the free-stack top are prefetched from memory.
//   Responses pass through a two-entry buffer, so one more request is taken
//   while a response waits; in_stall_o rises only when both entries are full.
//   Reset empties the queue at once; no clearing pass is needed. Commands are
//   never dropped while the receiver stalls.
module bucketed_priority_queue_top
  import bpq_pkg::*;
#(
  parameter int LEVELS   = 16,
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bpq_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bpq_rsp_t out_data_o
);

  localparam int LvlW  = $clog2(LEVELS);
  localparam int SlotW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);

  logic                accept;
  bpq_op_t             op;
  bpq_rsp_t            rsp;
  logic                full;
  logic                in_range;
  logic [LvlW+3:0]     prio_wide;
  logic [LvlW-1:0]     enq_level;
  logic [LvlW+3:0]     first_wide;
  logic [TAG_BITS+15:0] tag_in_wide;
  logic [TAG_BITS+15:0] tag_out_wide;
  logic [CntW+6:0]     count_wide;

  logic [SlotW-1:0]    enq_link, front_slot, front_slot_d, free_slot;
  logic [SlotW-1:0]    front_link;
  logic [TAG_BITS-1:0] front_tag;
  logic                any;
  logic [LvlW-1:0]     first;
  logic [CntW-1:0]     count_q, count_d;

  logic     out_valid_q, skid_valid_q;
  bpq_rsp_t out_data_q, skid_data_q;
  logic     out_fire;

  assign accept = in_valid_i && !skid_valid_q;

  assign prio_wide    = {{LvlW{1'b0}}, in_data_i.priority_req};
  assign enq_level    = prio_wide[LvlW-1:0];
  assign in_range     = 32'(in_data_i.priority_req) < 32'(LEVELS);
  assign full         = count_q == CntW'(CAPACITY);
  assign first_wide   = {4'b0, first};
  assign tag_in_wide  = {{TAG_BITS{1'b0}}, in_data_i.tag};
  assign tag_out_wide = {16'b0, front_tag};
  assign count_wide   = {7'b0, count_d};

  always_comb begin
    op               = '0;
    rsp.ok           = 1'b0;
    rsp.out_tag      = '0;
    rsp.out_priority = '0;
    unique case (in_data_i.cmd) inside
      CMD_ENQ: begin
        if (!full && in_range) begin
          op.enq = accept;
          rsp.ok = 1'b1;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (any) begin
          op.deq           = accept && (in_data_i.cmd == CMD_DEQ);
          rsp.ok           = 1'b1;
          rsp.out_tag      = tag_out_wide[15:0];
          rsp.out_priority = first_wide[3:0];
        end
      end
      default: begin
      end
    endcase
    rsp.count     = count_wide[6:0];
    rsp.empty_res = count_d == '0;
  end

  bpq_level_tbl #(
    .LEVELS  (LEVELS),
    .CAPACITY(CAPACITY)
  ) u_level_tbl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .enq_level_i   (enq_level),
    .enq_slot_i    (free_slot),
    .deq_link_i    (front_link),
    .enq_link_o    (enq_link),
    .any_o         (any),
    .first_o       (first),
    .front_slot_o  (front_slot),
    .front_slot_d_o(front_slot_d)
  );

  bpq_node_mem #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_node_mem (
    .clk_i    (clk_i),
    .we_i     (op.enq),
    .wr_slot_i(free_slot),
    .wr_link_i(enq_link),
    .wr_tag_i (tag_in_wide[TAG_BITS-1:0]),
    .rd_slot_i(front_slot_d),
    .rd_link_o(front_link),
    .rd_tag_o (front_tag)
  );

  bpq_free_stack #(
    .CAPACITY(CAPACITY)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .push_slot_i(front_slot),
    .top_slot_o (free_slot),
    .count_q_o  (count_q),
    .count_d_o  (count_d)
  );

  // Two-entry response buffer; the skid entry drains into the output first.
  assign out_fire = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= rsp;
      end else begin
        skid_data_q <= rsp;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
